// ----- rtl/core/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared types, character codes and decode helpers for the unescape block.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0]  UTF_LEAD2   = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3   = 8'hE0;
    localparam logic [7:0]  UTF_CONT    = 8'h80;
    localparam logic [15:0] UTF_TWO_MIN = 16'h0080;
    localparam logic [15:0] UTF_THR_MIN = 16'h0800;

    typedef enum logic [2:0] {
        PH_PLAIN = 3'd0,
        PH_ESC   = 3'd1,
        PH_HEX1  = 3'd2,
        PH_HEX2  = 3'd3,
        PH_HEX3  = 3'd4,
        PH_HEX4  = 3'd5
    } phase_t;

    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
        logic            byte_valid;
        logic            string_end;
        logic            unterminated;
    } cmd_t;

    function automatic logic [3:0] hex_value(input logic [7:0] h);
        logic [3:0] v;
        v = 4'd0;
        if (h >= 8'h30 && h <= 8'h39) v = 4'(h - 8'h30);
        else if (h >= 8'h61 && h <= 8'h66) v = 4'(h - 8'h57);
        else if (h >= 8'h41 && h <= 8'h46) v = 4'(h - 8'h37);
        return v;
    endfunction

    function automatic logic [7:0] escape_map(input logic [7:0] e);
        logic [7:0] r;
        case (e)
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            default: r = e;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/jsu_front.sv -----
// ----------------------------------------------------------------------------
// JSON string unescape front end
// Accepts raw string bytes, tracks escape state and builds one output command.
// ----------------------------------------------------------------------------
module jsu_front (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [7:0]  in_byte,
    input  logic        in_eoi,
    input  logic        in_ready,
    output logic        push,
    output jsu_pkg::cmd_t cmd
);
    import jsu_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] accum_reg, accum_next;
    logic [15:0] accum_shift;
    logic        accept;
    logic        in_escape;
    logic        closed;

    assign accept      = in_valid && in_ready;
    assign accum_shift = {accum_reg[11:0], hex_value(in_byte)};
    assign in_escape   = (phase_reg == PH_ESC) || (phase_reg == PH_HEX1) ||
                         (phase_reg == PH_HEX2) || (phase_reg == PH_HEX3) ||
                         (phase_reg == PH_HEX4);
    assign closed      = !in_escape && (in_byte == CH_QUOTE);
    assign push        = accept && (cmd.cnt != 2'd0);

    always_comb
    begin
        phase_next = PH_PLAIN;
        accum_next = accum_reg;
        case (phase_reg)
            PH_ESC:
            begin
                if (in_byte == CH_U)
                begin
                    phase_next = PH_HEX1;
                    accum_next = '0;
                end
            end
            PH_HEX1:
            begin
                phase_next = PH_HEX2;
                accum_next = accum_shift;
            end
            PH_HEX2:
            begin
                phase_next = PH_HEX3;
                accum_next = accum_shift;
            end
            PH_HEX3:
            begin
                phase_next = PH_HEX4;
                accum_next = accum_shift;
            end
            PH_HEX4:
            begin
                accum_next = '0;
            end
            default:
            begin
                if (in_byte == CH_BSLASH && !in_eoi)
                begin
                    phase_next = PH_ESC;
                end
            end
        endcase
        if (in_eoi && !closed)
        begin
            phase_next = PH_PLAIN;
            accum_next = '0;
        end
    end

    always_comb
    begin
        cmd = '0;
        case (phase_reg)
            PH_ESC:
            begin
                if (in_byte != CH_U)
                begin
                    cmd.cnt        = 2'd1;
                    cmd.bytes[0]   = escape_map(in_byte);
                    cmd.byte_valid = 1'b1;
                end
            end
            PH_HEX1, PH_HEX2, PH_HEX3:
            begin
                cmd.cnt = 2'd0;
            end
            PH_HEX4:
            begin
                cmd.byte_valid = 1'b1;
                if (accum_shift < UTF_TWO_MIN)
                begin
                    cmd.cnt      = 2'd1;
                    cmd.bytes[0] = accum_shift[7:0];
                end
                else if (accum_shift < UTF_THR_MIN)
                begin
                    cmd.cnt      = 2'd2;
                    cmd.bytes[0] = UTF_LEAD2 | {3'b000, accum_shift[10:6]};
                    cmd.bytes[1] = UTF_CONT | {2'b00, accum_shift[5:0]};
                end
                else
                begin
                    cmd.cnt      = 2'd3;
                    cmd.bytes[0] = UTF_LEAD3 | {4'b0000, accum_shift[15:12]};
                    cmd.bytes[1] = UTF_CONT | {2'b00, accum_shift[11:6]};
                    cmd.bytes[2] = UTF_CONT | {2'b00, accum_shift[5:0]};
                end
            end
            default:
            begin
                if (in_byte == CH_QUOTE)
                begin
                    cmd.cnt        = 2'd1;
                    cmd.string_end = 1'b1;
                end
                else if (!(in_byte == CH_BSLASH && !in_eoi))
                begin
                    cmd.cnt        = 2'd1;
                    cmd.bytes[0]   = in_byte;
                    cmd.byte_valid = 1'b1;
                end
            end
        endcase
        if (in_eoi && !closed)
        begin
            if (cmd.cnt == 2'd0)
            begin
                cmd.cnt = 2'd1;
            end
            cmd.unterminated = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PLAIN;
            accum_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
        end
    end

    a_eoi_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_eoi |=> phase_reg == PH_PLAIN)
        else $error("Phase did not return to plain mode after end of input.");

endmodule

// ----- rtl/core/jsu_queue.sv -----
// ----------------------------------------------------------------------------
// JSON string unescape command queue
// Short first-in first-out buffer between the front end and the emitter.
// ----------------------------------------------------------------------------
module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jsu_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          have,
    output jsu_pkg::cmd_t head
);
    import jsu_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign have = (count_reg != '0);
    assign head = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("Command queue count exceeds its depth.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> have)
        else $error("Command queue popped while empty.");

endmodule

// ----- rtl/core/jsu_back.sv -----
// ----------------------------------------------------------------------------
// JSON string unescape emitter
// Walks each queued command and drives its results through an output register.
// ----------------------------------------------------------------------------
module jsu_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          have,
    input  jsu_pkg::cmd_t head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic [2:0]    out_user,
    output logic          out_last
);
    import jsu_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic [2:0] user_reg;
    logic       last_reg;
    logic       load;
    logic       is_last;

    assign load      = have && (!valid_reg || out_ready);
    assign is_last   = (idx_reg == 2'(head.cnt - 2'd1));
    assign pop       = load && is_last;
    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_user  = user_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = is_last ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head.bytes[idx_reg];
            user_reg <= {head.unterminated & is_last, head.string_end, head.byte_valid};
            last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        have |-> idx_reg < head.cnt)
        else $error("Result index runs past the command's result count.");

    a_error_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && user_reg[2] |-> last_reg)
        else $error("Unterminated flag appeared on a result that is not the last.");

endmodule

// ----- rtl/core/json_string_unescape_top.sv -----
// ----------------------------------------------------------------------------
// JSON string unescape top level
// Decodes the body of a JSON string into UTF-8 bytes, one raw byte per request.
// ----------------------------------------------------------------------------
// The slave channel takes one raw byte of the string body per request, starting
// after the opening quote; tlast marks the last available text byte. The master
// channel gives one decoded result per request: tdata holds the byte, tuser the
// flags, and tlast marks the last result caused by one input byte.
// A byte is classified in the cycle it is accepted and its results are placed
// in a command queue; from the queue they are loaded into the output register,
// which drives the master side. An input byte yields zero to three results,
// and the last hex digit of a \u escape can yield a three-byte UTF-8 sequence;
// the single output register sends one result per cycle while results are
// queued and the receiver is ready. Input is accepted every cycle while the
// queue of DEPTH commands has room.
// Reset puts the decoder in plain mode, empties the queue and drops tvalid.
// When the receiver stalls, the output holds, the queue fills and s_axis_tready
// falls; no result is lost.
// ----------------------------------------------------------------------------
module json_string_unescape_top #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] out_byte
    output logic [2:0] m_axis_tuser,  // [0] byte_valid, [1] string_end, [2] unterminated
    output logic       m_axis_tlast
);
    import jsu_pkg::*;

    logic full;
    logic have;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t head;

    assign s_axis_tready = !full;

    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_byte  (s_axis_tdata),
        .in_eoi   (s_axis_tlast),
        .in_ready (s_axis_tready),
        .push     (push),
        .cmd      (push_cmd)
    );

    jsu_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (full),
        .have     (have),
        .head     (head)
    );

    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .have      (have),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule
